/* design/kct_pkg.sv */
// Shared types and constants for the keypad countdown timer controller.
// No dependencies; every other design file imports this package.
package kct_pkg;

  typedef logic [3:0] bcd_t;
  typedef bcd_t [3:0] bcd4_t;  // index 0 is the ones digit

  typedef enum logic [1:0] {
    KIND_DASH = 2'd0,
    KIND_NUM  = 2'd1,
    KIND_END  = 2'd2
  } kind_e;

  typedef enum logic {
    CFG_TICK_PERIOD = 1'b0,
    CFG_END_HOLD    = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic       mode;
    logic [4:0] key_code;
  } kct_req_t;

  typedef struct packed {
    logic [1:0]  display_kind;
    logic [13:0] shown_value;
    logic [7:0]  seg_ones;
    logic [7:0]  seg_tens;
    logic [7:0]  seg_hundreds;
    logic [7:0]  seg_thousands;
    logic        counting;
  } kct_res_t;

  typedef struct packed {
    kind_e           kind;
    logic [13:0]     value;
    logic [3:0][7:0] seg;  // index 0 is the rightmost digit
  } disp_t;

  localparam logic [7:0]  SEG_DASH  = 8'hbf;
  localparam logic [7:0]  SEG_END_D = 8'ha1;
  localparam logic [7:0]  SEG_END_N = 8'hab;
  localparam logic [7:0]  SEG_END_E = 8'h86;

  localparam logic [4:0]  KEY_MAX    = 5'd16;
  localparam logic [4:0]  CODE_EDIT  = 5'd13;
  localparam logic [4:0]  CODE_START = 5'd16;
  localparam logic [4:0]  CODE_NONE  = 5'd12;
  localparam logic [4:0]  CODE_ZERO_ALIAS = 5'd11;
  localparam logic [4:0]  DIGIT_LIMIT = 5'd10;
  localparam logic [4:0]  CMD_BASE   = 5'd12;

  localparam logic [15:0] TICK_PERIOD_RST = 16'd99;
  localparam logic [15:0] END_HOLD_RST    = 16'd500;

endpackage

/* design/kct_if.sv */
// Valid/ready channel interfaces for requests and results.
// Depends on kct_pkg for the payload structs.
interface kct_in_if;
  import kct_pkg::*;
  logic     valid;
  logic     ready;
  kct_req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface kct_out_if;
  import kct_pkg::*;
  logic     valid;
  logic     ready;
  kct_res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/kct_disp.sv */
// Display encoder: turns the selected mode and BCD count into the shown
// value and four active-low seven-segment codes. Depends on kct_pkg.
module kct_disp (
  input  logic          numeric_i,
  input  logic          finished_i,
  input  kct_pkg::bcd4_t count_i,
  output kct_pkg::disp_t disp_o
);
  import kct_pkg::*;

  function automatic logic [7:0] seg_digit(bcd_t d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'hc0;
      4'd1:    s = 8'hf9;
      4'd2:    s = 8'ha4;
      4'd3:    s = 8'hb0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hd8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h90;
      default: s = SEG_DASH;
    endcase
    return s;
  endfunction

  logic [13:0] bin_value;

  // The count is held in BCD, so the binary value is a sum of constant products.
  assign bin_value = 14'(count_i[3]) * 14'd1000 + 14'(count_i[2]) * 14'd100
                   + 14'(count_i[1]) * 14'd10 + 14'(count_i[0]);

  always_comb begin
    if (numeric_i) begin
      disp_o.kind  = KIND_NUM;
      disp_o.value = bin_value;
      for (int i = 0; i < 4; i++) begin
        disp_o.seg[i] = seg_digit(count_i[i]);
      end
    end else if (finished_i) begin
      disp_o.kind   = KIND_END;
      disp_o.value  = '0;
      disp_o.seg[0] = SEG_END_D;
      disp_o.seg[1] = SEG_END_N;
      disp_o.seg[2] = SEG_END_E;
      disp_o.seg[3] = SEG_DASH;
    end else begin
      disp_o.kind   = KIND_DASH;
      disp_o.value  = '0;
      disp_o.seg    = {4{SEG_DASH}};
    end
  end

endmodule

/* design/keypad_countdown_timer_controller_unit.sv */
// Top level of the keypad countdown timer controller: state update per
// request, two-entry result buffer. Depends on kct_pkg, kct_if, kct_disp.
//
//   channel  | dir | handshake           | payload
//   ---------+-----+---------------------+-------------------------------------
//   in_if    | in  | valid/ready         | mode, key_code
//   out_if   | out | valid/ready         | display_kind, shown_value, seg_*,
//            |     |                     | counting
//   cfg      | in  | cfg_we_i, no wait   | cfg_idx_i, cfg_wdata_i
//
// One request per cycle while in_if.ready is high; its result is registered
// in out_q, or in skid_q under a stall. The state update and display
// encoding are one short combinational pass into the result register. A second
// result register absorbs a stall, and in_if.ready drops only while both are full.
// Reset clears all timer state and loads the register defaults.
module keypad_countdown_timer_controller_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  kct_in_if.sink            in_if,
  kct_out_if.source         out_if,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [15:0]       cfg_wdata_i
);
  import kct_pkg::*;

  function automatic logic [4:0] remap_key(logic [4:0] k);
    logic [2:0] row;
    logic [1:0] col;
    logic [4:0] v;
    row = k[4:2];
    col = k[1:0];
    if (k > KEY_MAX) begin
      v = CODE_NONE;
    end else if (col == 2'd0) begin
      v = CMD_BASE + 5'(row);
    end else begin
      v = 5'(3 * row + col);
      if (v == CODE_ZERO_ALIAS) begin
        v = '0;
      end
    end
    return v;
  endfunction

  function automatic bcd4_t bcd_dec(bcd4_t v);
    bcd4_t r;
    logic  borrow;
    r      = v;
    borrow = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (borrow) begin
        if (r[i] == 4'd0) begin
          r[i] = 4'd9;
        end else begin
          r[i]   = r[i] - 4'd1;
          borrow = 1'b0;
        end
      end
    end
    return r;
  endfunction

  logic [15:0] tick_period_q, end_hold_q;
  logic        editing_q, editing_d;
  logic        running_q, running_d;
  logic        finished_q, finished_d;
  bcd4_t       entry_q, entry_d;
  bcd4_t       count_q, count_d;
  logic [15:0] tick_q, tick_d;

  logic        accept;
  logic [4:0]  code;
  logic        run_sel;
  logic        disp_numeric;
  bcd4_t       disp_count;
  disp_t       disp;
  kct_res_t    res;

  kct_res_t    out_q, skid_q;
  logic        out_vq, skid_vq;
  logic        out_take;

  assign accept   = in_if.valid && in_if.ready;
  assign code     = remap_key(in_if.data.key_code);
  assign out_take = out_vq && out_if.ready;

  always_comb begin
    editing_d    = editing_q;
    running_d    = running_q;
    finished_d   = finished_q;
    entry_d      = entry_q;
    count_d      = count_q;
    tick_d       = tick_q;
    run_sel      = running_q;
    disp_numeric = editing_q || running_q;
    disp_count   = count_q;
    if (accept) begin
      if (in_if.data.mode) begin
        tick_d = tick_q + 16'd1;
      end else begin
        if (code == CODE_EDIT) begin
          editing_d = 1'b1;
        end else if (code == CODE_START) begin
          running_d = 1'b1;
          editing_d = 1'b0;
          tick_d    = '0;
        end
        run_sel = running_d;
        if (editing_d) begin
          if (code < DIGIT_LIMIT) begin
            entry_d = {entry_q[2:0], code[3:0]};
          end
          count_d = entry_d;
        end else if (running_d) begin
          if (tick_d >= tick_period_q) begin
            if (count_q != '0) begin
              count_d = bcd_dec(count_q);
              tick_d  = '0;
            end else begin
              // Count ran out: stop and raise the end message.
              entry_d    = '0;
              running_d  = 1'b0;
              finished_d = 1'b1;
            end
          end
        end else if (finished_q) begin
          if (tick_d >= end_hold_q) begin
            finished_d = 1'b0;
          end
        end
        disp_numeric = editing_d || run_sel;
        disp_count   = count_d;
      end
    end
  end

  kct_disp u_disp (
    .numeric_i  (disp_numeric),
    .finished_i (finished_q),
    .count_i    (disp_count),
    .disp_o     (disp)
  );

  always_comb begin
    res.display_kind  = disp.kind;
    res.shown_value   = disp.value;
    res.seg_ones      = disp.seg[0];
    res.seg_tens      = disp.seg[1];
    res.seg_hundreds  = disp.seg[2];
    res.seg_thousands = disp.seg[3];
    res.counting      = running_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_period_q <= TICK_PERIOD_RST;
      end_hold_q    <= END_HOLD_RST;
      editing_q     <= 1'b0;
      running_q     <= 1'b0;
      finished_q    <= 1'b0;
      entry_q       <= '0;
      count_q       <= '0;
      tick_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_TICK_PERIOD: tick_period_q <= cfg_wdata_i;
          CFG_END_HOLD:    end_hold_q    <= cfg_wdata_i;
          default:         ;
        endcase
      end
      editing_q  <= editing_d;
      running_q  <= running_d;
      finished_q <= finished_d;
      entry_q    <= entry_d;
      count_q    <= count_d;
      tick_q     <= tick_d;
    end
  end

  // Result buffer: out_q is shown, skid_q holds one more result under a stall.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq  <= 1'b0;
      skid_vq <= 1'b0;
    end else begin
      if (out_take && skid_vq) begin
        skid_vq <= 1'b0;
      end else if (accept) begin
        if (!out_vq || out_take) begin
          out_vq <= 1'b1;
        end else begin
          skid_vq <= 1'b1;
        end
      end else if (out_take) begin
        out_vq <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take && skid_vq) begin
      out_q <= skid_q;
    end else if (accept) begin
      if (!out_vq || out_take) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign in_if.ready  = !skid_vq;
  assign out_if.valid = out_vq;
  assign out_if.data  = out_q;

endmodule

/* tb/kct_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the keypad countdown timer controller: follows the timer state from
// the requests and register writes it observes and compares every result it sees.
// Depends on kct_pkg and the kct_in_if / kct_out_if channel interfaces.
module kct_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  kct_in_if           req_if,
  kct_out_if          res_if,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  output int          pending_o,
  output int          errors_o
);
  import kct_pkg::*;

  localparam logic [7:0] DIGIT_SEG [10] = '{
    8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hd8, 8'h80, 8'h90
  };

  logic [15:0] tick_period;
  logic [15:0] end_hold;
  logic        editing;
  logic        running;
  logic        finished;
  bcd4_t       entry;
  logic [13:0] count_val;
  logic [15:0] tick_cnt;
  kct_res_t    display_q [$];

  function automatic logic [4:0] key_to_code(logic [4:0] key);
    logic [4:0] row;
    logic [4:0] col;
    logic [4:0] code;
    if (key > KEY_MAX) return CODE_NONE;
    row = 5'(key / 4);
    col = 5'(key % 4);
    // The rightmost column of the keypad holds the command keys.
    if (col == 0) return CMD_BASE + row;
    code = 5'(3 * row + col);
    return (code == CODE_ZERO_ALIAS) ? 5'd0 : code;
  endfunction

  function automatic kct_res_t show_number(logic [13:0] value);
    kct_res_t r;
    int       n;
    n               = int'(value);
    r.display_kind  = KIND_NUM;
    r.shown_value   = value;
    r.seg_ones      = DIGIT_SEG[n % 10];
    r.seg_tens      = DIGIT_SEG[(n / 10) % 10];
    r.seg_hundreds  = DIGIT_SEG[(n / 100) % 10];
    r.seg_thousands = DIGIT_SEG[(n / 1000) % 10];
    r.counting      = 1'b0;
    return r;
  endfunction

  // Display priority: edit or countdown, then the end message, then dashes.
  function automatic kct_res_t show_state();
    kct_res_t r;
    if (editing || running) return show_number(count_val);
    r = '0;
    if (finished) begin
      r.display_kind  = KIND_END;
      r.seg_ones      = SEG_END_D;
      r.seg_tens      = SEG_END_N;
      r.seg_hundreds  = SEG_END_E;
      r.seg_thousands = SEG_DASH;
    end else begin
      r.display_kind  = KIND_DASH;
      r.seg_ones      = SEG_DASH;
      r.seg_tens      = SEG_DASH;
      r.seg_hundreds  = SEG_DASH;
      r.seg_thousands = SEG_DASH;
    end
    return r;
  endfunction

  function automatic kct_res_t apply_request(kct_req_t req);
    kct_res_t   r;
    logic [4:0] code;
    // A set mode bit is a 10 ms tick; it only advances the tick counter.
    if (req.mode) begin
      tick_cnt   = tick_cnt + 16'd1;
      r          = show_state();
      r.counting = running;
      return r;
    end
    code = key_to_code(req.key_code);
    if (code == CODE_EDIT) begin
      editing = 1'b1;
    end else if (code == CODE_START) begin
      running  = 1'b1;
      editing  = 1'b0;
      tick_cnt = '0;
    end
    if (editing) begin
      if (code < DIGIT_LIMIT) entry = {entry[2:0], code[3:0]};
      count_val = 14'(1000 * int'(entry[3]) + 100 * int'(entry[2]) +
                      10 * int'(entry[1]) + int'(entry[0]));
      r = show_state();
    end else if (running) begin
      if (tick_cnt >= tick_period) begin
        if (count_val != 0) begin
          count_val = count_val - 14'd1;
          tick_cnt  = '0;
        end else begin
          entry    = '0;
          running  = 1'b0;
          finished = 1'b1;
        end
      end
      // The poll that stops the countdown still shows the value zero.
      r = show_number(count_val);
    end else begin
      r = show_state();
      if (finished && tick_cnt >= end_hold) finished = 1'b0;
    end
    r.counting = running;
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    kct_res_t want;
    kct_res_t got;
    if (!rst_ni) begin
      tick_period = TICK_PERIOD_RST;
      end_hold    = END_HOLD_RST;
      editing     = 1'b0;
      running     = 1'b0;
      finished    = 1'b0;
      entry       = '0;
      count_val   = '0;
      tick_cnt    = '0;
      display_q.delete();
    end else begin
      if (res_if.valid && res_if.ready) begin
        got = res_if.data;
        if (display_q.size() == 0) begin
          $error("result arrived with no request outstanding");
          errors_o++;
        end else begin
          want = display_q.pop_front();
          check_field("display_kind", 16'(want.display_kind), 16'(got.display_kind));
          check_field("shown_value", 16'(want.shown_value), 16'(got.shown_value));
          check_field("seg_ones", 16'(want.seg_ones), 16'(got.seg_ones));
          check_field("seg_tens", 16'(want.seg_tens), 16'(got.seg_tens));
          check_field("seg_hundreds", 16'(want.seg_hundreds), 16'(got.seg_hundreds));
          check_field("seg_thousands", 16'(want.seg_thousands), 16'(got.seg_thousands));
          check_field("counting", 16'(want.counting), 16'(got.counting));
        end
      end
      if (req_if.valid && req_if.ready) display_q.push_back(apply_request(req_if.data));
      if (cfg_we_i) begin
        if (cfg_idx_e'(cfg_idx_i) == CFG_TICK_PERIOD) tick_period = cfg_wdata_i;
        else end_hold = cfg_wdata_i;
      end
    end
    pending_o = display_q.size();
  end

endmodule

/* tb/tb_keypad_countdown_timer_controller_unit.sv */
`timescale 1ns / 1ps
// Top of the keypad countdown timer testbench: clock, reset, request and register
// stimulus, random result stalls and the verdict. Depends on kct_pkg, the channel
// interfaces, kct_checker and the timer controller itself.
module tb_keypad_countdown_timer_controller_unit;
  import kct_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 1420;

  localparam logic       MODE_POLL    = 1'b0;
  localparam logic       MODE_TICK    = 1'b1;
  localparam logic [4:0] KEY_NONE     = 5'd0;
  localparam logic [4:0] KEY_EDIT     = 5'd4;
  localparam logic [4:0] KEY_START    = 5'd16;
  localparam logic [4:0] KEY_MAX_CODE = 5'd31;
  // Raw key for each decimal digit, indexed by the digit.
  localparam logic [4:0] DIGIT_KEY [10] = '{
    5'd14, 5'd1, 5'd2, 5'd3, 5'd5, 5'd6, 5'd7, 5'd9, 5'd10, 5'd11
  };
  // Raw keys that decode to commands or codes with no action of their own.
  localparam logic [4:0] KEY_IDLE_CMD [4] = '{5'd8, 5'd12, 5'd13, 5'd15};

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_idx;
  logic [15:0] cfg_wdata;
  int          pending;
  int          errors;
  int          cycles = 0;
  int          sent_items = 0;
  int          setting_count = 0;
  int          starts = 0;
  int          stall_left = 0;
  bit          calm_phase = 1'b0;
  int unsigned cur_period;
  int unsigned cur_hold;

  kct_in_if  in_ch ();
  kct_out_if out_ch ();

  keypad_countdown_timer_controller_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  kct_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_if      (in_ch),
    .res_if      (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding", cycles, pending);
      $display("tb_keypad_countdown_timer_controller_unit: errors");
      $finish;
    end
  end

  // Mostly no wait, sometimes a short one and now and then a long one.
  function automatic int pick_delay();
    int r;
    if (calm_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  always @(negedge clk) begin : result_sink
    int n;
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      n = $urandom_range(0, 1) ? pick_delay() : 0;
      out_ch.ready <= (n == 0);
      stall_left = (n > 0) ? n - 1 : 0;
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(input logic is_tick, input logic [4:0] key);
    int gap;
    gap = pick_delay();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= '{mode: is_tick, key_code: key};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    sent_items++;
  endtask

  // Registers change only once every outstanding result has come back.
  task automatic load_settings(input logic [15:0] period, input logic [15:0] hold);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_TICK_PERIOD;
    cfg_wdata <= period;
    @(negedge clk);
    cfg_idx   <= CFG_END_HOLD;
    cfg_wdata <= hold;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_period = 32'(period);
    cur_hold   = 32'(hold);
    setting_count++;
  endtask

  // Expects a tick period of 1 and an end hold of 2.
  task automatic directed_run();
    send_request(MODE_TICK, KEY_NONE);
    send_request(MODE_POLL, KEY_NONE);
    send_request(MODE_POLL, KEY_MAX_CODE);
    send_request(MODE_POLL, KEY_EDIT);
    send_request(MODE_POLL, DIGIT_KEY[9]);
    repeat (3) send_request(MODE_POLL, DIGIT_KEY[0]);
    foreach (KEY_IDLE_CMD[i]) send_request(MODE_POLL, KEY_IDLE_CMD[i]);
    // With the next digit the entry reads 0001, so the countdown ends within a few requests.
    send_request(MODE_POLL, DIGIT_KEY[1]);
    send_request(MODE_POLL, KEY_START);
    send_request(MODE_TICK, KEY_NONE);
    send_request(MODE_POLL, KEY_NONE);
    send_request(MODE_TICK, KEY_NONE);
    send_request(MODE_POLL, KEY_NONE);
    send_request(MODE_TICK, KEY_MAX_CODE);
    // Edit mode must take the display back from the end message.
    send_request(MODE_POLL, KEY_EDIT);
    send_request(MODE_POLL, KEY_START);
    repeat (2) send_request(MODE_TICK, KEY_NONE);
    repeat (3) send_request(MODE_POLL, KEY_NONE);
    starts += 2;
  endtask

  task automatic countdown_run();
    int unsigned value;
    int unsigned target;
    int unsigned ticks;
    int unsigned steps;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 60) value = $urandom_range(0, 9);
    else if (r < 85) value = $urandom_range(10, 99);
    else value = $urandom_range(100, 9999);
    // A few sequences leave out the edit or the start key on purpose.
    if ($urandom_range(0, 99) >= 6) send_request(MODE_POLL, KEY_EDIT);
    for (int i = 3; i >= 0; i--) begin
      if ($urandom_range(0, 99) < 5) send_request(MODE_POLL, 5'($urandom_range(0, 31)));
      send_request(MODE_POLL, DIGIT_KEY[(value / (10 ** i)) % 10]);
    end
    if ($urandom_range(0, 99) >= 6) begin
      send_request(MODE_POLL, KEY_START);
      starts++;
    end
    target = (value + 1) * cur_period + cur_hold + 2;
    ticks  = 0;
    steps  = 0;
    while (ticks < target && steps < 200) begin
      if ($urandom_range(0, 99) < 70) begin
        send_request(MODE_TICK, 5'($urandom_range(0, 31)));
        ticks++;
      end else if ($urandom_range(0, 99) < 85) begin
        send_request(MODE_POLL, KEY_NONE);
      end else begin
        send_request(MODE_POLL, 5'($urandom_range(0, 31)));
      end
      steps++;
    end
    send_request(MODE_POLL, KEY_NONE);
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 8))
      send_request(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)));
  endtask

  initial begin
    int          phase;
    int          budget;
    int          stop_at;
    logic [15:0] period;
    logic [15:0] hold;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_TICK_PERIOD;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    load_settings(16'd1, 16'd2);
    directed_run();

    phase = 0;
    while (sent_items < ITEM_TARGET) begin
      case (phase)
        0: begin
          period = 16'd1;
          hold   = 16'd0;
          budget = 100;
        end
        1: begin
          period = 16'hffff;
          hold   = 16'hffff;
          budget = 40;
        end
        2: begin
          period = TICK_PERIOD_RST;
          hold   = END_HOLD_RST;
          budget = 60;
        end
        3: begin
          period = 16'($urandom_range(1, 65535));
          hold   = 16'($urandom_range(0, 65535));
          budget = 40;
        end
        default: begin
          period = 16'($urandom_range(1, 4));
          hold   = 16'($urandom_range(0, 12));
          budget = 130;
        end
      endcase
      calm_phase = (phase % 4 == 2);
      load_settings(period, hold);
      stop_at = sent_items + budget;
      while (sent_items < stop_at) begin
        if ($urandom_range(0, 3) != 0) countdown_run();
        else noise_burst();
      end
      phase++;
    end

    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    $display("Sent %0d timer requests under %0d register settings, %0d countdown starts.",
             sent_items, setting_count, starts);
    if (errors == 0) begin
      $display("tb_keypad_countdown_timer_controller_unit: clean");
    end else begin
      $display("tb_keypad_countdown_timer_controller_unit: errors");
    end
    $finish;
  end

endmodule
